// ===== sv/a85s_pkg.sv =====
// Shared types and constants for the Ascii85 stream encoder.
`default_nettype none

package a85s_pkg;

   // Base-85 digit alphabet.
   localparam logic [6:0] A85S_BASE      = 7'd85;
   localparam logic [6:0] A85S_OFFSET    = 7'd33;
   localparam logic [6:0] A85S_ZERO_CHAR = 7'd122;
   localparam logic [6:0] A85S_MAX_CHAR  = A85S_OFFSET + A85S_BASE - 7'd1;

   // Digits per full group and characters sent for a full group.
   localparam int A85S_DIGITS = 5;
   localparam logic [2:0] A85S_FULL_CHARS = 3'd5;

   // Division by 85 as a multiply by a reciprocal: q = (w * RECIP) >> SHIFT.
   // The reciprocal is rounded up; the error term keeps q exact for any
   // 32-bit w.
   localparam int A85S_RECIP_SHIFT = 38;
   localparam logic [31:0] A85S_RECIP = 32'd3233857729;
   localparam int A85S_PROD_W = 64;
   localparam int A85S_QUOT_W = A85S_PROD_W - A85S_RECIP_SHIFT;

   // Depth of the group queue between front and back.
   localparam int A85S_QUEUE_DEPTH = 2;

   // One request: a raw byte and the end-of-stream flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } a85s_req_type;

   // One response: an output character and the end-of-stream flag.
   typedef struct packed {
      logic [6:0] out_char;
      logic       last_char;
   } a85s_rsp_type;

   // One closed group, ready for conversion.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  n_char;
      logic        zero_group;
      logic        last_group;
   } a85s_group_type;

endpackage

`default_nettype wire

// ===== sv/ascii85_stream_encoder.sv =====
// Top level of the Ascii85 stream encoder.
//
//   Channel   Ports                          Moves
//   -------   -----------------------------  -----------------------------------
//   request   req_valid, req_ready, req_data  one raw byte and its last flag
//   response  rsp_valid, rsp_ready, rsp_data  one character and its last flag
//
// The front end takes one request per cycle while the queue has room; a group
// closes on its fourth byte or on a byte with the last flag set and enters a
// two-entry queue. The back end converts one group with a load and five digit
// steps (through one shared 32x32 multiply by the reciprocal of 85), overlapped
// with sending the previous group's characters one per cycle while the response
// side is ready.
// Reset is synchronous and active high and clears the open group and the queue.
// Either side may stall at any time; the queue and the emitter register let the
// other side keep working.
`default_nettype none

module ascii85_stream_encoder #(
   parameter int QUEUE_DEPTH = a85s_pkg::A85S_QUEUE_DEPTH
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  a85s_pkg::a85s_req_type   req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output a85s_pkg::a85s_rsp_type   rsp_data
);
   import a85s_pkg::*;

   logic           push_valid;
   logic           push_ready;
   a85s_group_type push_data;
   logic           pop_valid;
   logic           pop_ready;
   a85s_group_type pop_data;

   // Byte gathering and group closing.
   a85s_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .grp_valid (push_valid),
      .grp_ready (push_ready),
      .grp_data  (push_data)
   );

   // Queue of closed groups.
   a85s_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Digit conversion and character output.
   a85s_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (pop_valid),
      .grp_ready (pop_ready),
      .grp_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/a85s_front.sv =====
// Front end: gathers request bytes into groups and closes them.
`default_nettype none

module a85s_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  a85s_pkg::a85s_req_type     req_data,
   output logic                       grp_valid,
   input  wire                        grp_ready,
   output a85s_pkg::a85s_group_type   grp_data
);
   import a85s_pkg::*;

   logic [23:0] pend_ff, pend_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        accept;
   logic        closes;
   logic [31:0] joined;
   logic [4:0]  pad_shift;

   // Classify the request: a fourth byte or a last byte closes a group.
   always_comb begin
      joined    = {pend_ff, req_data.data_byte};
      closes    = (cnt_ff == 2'd3) || req_data.last_byte;
      req_ready = grp_ready;
      accept    = req_valid && req_ready;
      grp_valid = req_valid && closes;
      pad_shift = {2'd3 - cnt_ff, 3'b000};

      if (cnt_ff == 2'd3) begin
         grp_data.word       = joined;
         grp_data.n_char     = A85S_FULL_CHARS;
         grp_data.zero_group = (joined == 32'd0);
         grp_data.last_group = req_data.last_byte;
      end else begin
         // Partial final group: pad with zero bytes, emit one digit more than its bytes.
         grp_data.word       = joined << pad_shift;
         grp_data.n_char     = {1'b0, cnt_ff} + 3'd2;
         grp_data.zero_group = 1'b0;
         grp_data.last_group = 1'b1;
      end
   end

   // Byte gathering state.
   always_comb begin
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         if (closes) begin
            pend_in = 24'd0;
            cnt_in  = 2'd0;
         end else begin
            pend_in = {pend_ff[15:0], req_data.data_byte};
            cnt_in  = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 24'd0;
         cnt_ff  <= 2'd0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/a85s_queue.sv =====
// Short queue of closed groups between the front and back ends.
`default_nettype none

module a85s_queue #(
   parameter int DEPTH = a85s_pkg::A85S_QUEUE_DEPTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push_valid,
   output logic                       push_ready,
   input  a85s_pkg::a85s_group_type   push_data,
   output logic                       pop_valid,
   input  wire                        pop_ready,
   output a85s_pkg::a85s_group_type   pop_data
);
   import a85s_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   a85s_group_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // Handshake and pointer updates.
   always_comb begin
      push_ready = (count_ff != FULL_CNT);
      pop_valid  = (count_ff != '0);
      pop_data   = mem_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/a85s_back.sv =====
// Back end: converts groups to base-85 digits and sends the characters.
`default_nettype none

module a85s_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        grp_valid,
   output logic                       grp_ready,
   input  a85s_pkg::a85s_group_type   grp_data,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output a85s_pkg::a85s_rsp_type     rsp_data
);
   import a85s_pkg::*;

   // Converter state.
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [2:0]             step_ff, step_in;
   logic [31:0]            w_ff, w_in;
   logic [A85S_PROD_W-1:0] prod_ff, prod_in;
   logic [6:0]             dig_ff [A85S_DIGITS];
   logic [6:0]             dig_in [A85S_DIGITS];
   logic [2:0]             n_ff, n_in;
   logic                   zero_ff, zero_in;
   logic                   last_ff, last_in;

   // Character emitter state.
   logic [6:0]             em_chars_ff [A85S_DIGITS];
   logic [6:0]             em_chars_in [A85S_DIGITS];
   logic [2:0]             em_cnt_ff, em_cnt_in;
   logic                   em_last_ff, em_last_in;

   logic [A85S_QUOT_W-1:0] quot;
   logic [31:0]            rem_full;
   logic [6:0]             digit;
   logic [31:0]            mul_a;
   logic                   pop;
   logic                   em_free;
   logic                   handoff;

   // One digit per cycle: the registered product gives w/85, the
   // remainder is the digit, and the quotient feeds the next multiply.
   always_comb begin
      quot     = prod_ff[A85S_PROD_W-1:A85S_RECIP_SHIFT];
      rem_full = w_ff - (32'(quot) * 32'(A85S_BASE));
      digit    = rem_full[6:0];
      mul_a    = busy_ff ? 32'(quot) : grp_data.word;
      prod_in  = {32'd0, mul_a} * {32'd0, A85S_RECIP};

      em_free   = (em_cnt_ff == 3'd0) || ((em_cnt_ff == 3'd1) && rsp_ready);
      handoff   = done_ff && em_free;
      grp_ready = !busy_ff && (!done_ff || handoff);
      pop       = grp_valid && grp_ready;
   end

   // Converter sequencing.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      w_in    = w_ff;
      n_in    = n_ff;
      zero_in = zero_ff;
      last_in = last_ff;
      for (int k = 0; k < A85S_DIGITS; k++) begin
         dig_in[k] = dig_ff[k];
      end

      if (handoff) begin
         done_in = 1'b0;
      end

      if (pop) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         w_in    = grp_data.word;
         n_in    = grp_data.n_char;
         zero_in = grp_data.zero_group;
         last_in = grp_data.last_group;
      end else if (busy_ff) begin
         // Digits arrive least significant first; shifting up leaves the
         // most significant digit at index zero after the last step.
         dig_in[0] = digit;
         for (int k = 1; k < A85S_DIGITS; k++) begin
            dig_in[k] = dig_ff[k-1];
         end
         w_in    = 32'(quot);
         step_in = step_ff + 3'd1;
         if (step_ff == 3'(A85S_DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Emitter: holds the characters of one group and sends one a cycle while rsp_ready is high.
   always_comb begin
      em_cnt_in  = em_cnt_ff;
      em_last_in = em_last_ff;
      for (int k = 0; k < A85S_DIGITS; k++) begin
         em_chars_in[k] = em_chars_ff[k];
      end

      if (handoff) begin
         em_last_in = last_ff;
         if (zero_ff) begin
            em_chars_in[0] = A85S_ZERO_CHAR;
            em_cnt_in      = 3'd1;
         end else begin
            for (int k = 0; k < A85S_DIGITS; k++) begin
               em_chars_in[k] = A85S_OFFSET + dig_ff[k];
            end
            em_cnt_in = n_ff;
         end
      end else if (rsp_valid && rsp_ready) begin
         for (int k = 0; k < A85S_DIGITS - 1; k++) begin
            em_chars_in[k] = em_chars_ff[k+1];
         end
         em_cnt_in = em_cnt_ff - 3'd1;
      end

      rsp_valid          = (em_cnt_ff != 3'd0);
      rsp_data.out_char  = em_chars_ff[0];
      rsp_data.last_char = em_last_ff && (em_cnt_ff == 3'd1);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         em_cnt_ff <= 3'd0;
      end else begin
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         em_cnt_ff <= em_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      w_ff       <= w_in;
      prod_ff    <= prod_in;
      n_ff       <= n_in;
      zero_ff    <= zero_in;
      last_ff    <= last_in;
      em_last_ff <= em_last_in;
      for (int k = 0; k < A85S_DIGITS; k++) begin
         dig_ff[k]      <= dig_in[k];
         em_chars_ff[k] <= em_chars_in[k];
      end
   end

`ifndef SYNTHESIS
   // A group is either being converted or waiting for the emitter.
   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("converter busy and done at once");

   // The step counter stays within one group's digits.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= 3'(A85S_DIGITS - 1)))
      else $error("converter step out of range");

   // The emitter never holds more than a full group of characters.
   a_em_cnt_range: assert property (@(posedge clock) disable iff (reset)
      em_cnt_ff <= A85S_FULL_CHARS)
      else $error("emitter count out of range");

   // Every character sent is a base-85 digit or the zero-group mark.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.out_char != A85S_ZERO_CHAR)) |->
      ((rsp_data.out_char >= A85S_OFFSET) && (rsp_data.out_char <= A85S_MAX_CHAR)))
      else $error("character outside the base-85 alphabet");

   // A handed-off group is on the response channel in the next cycle.
   a_handoff_shows: assert property (@(posedge clock) disable iff (reset)
      handoff |=> rsp_valid)
      else $error("handed-off group not presented");
`endif

endmodule

`default_nettype wire

// ===== test/ascii85_stream_encoder_checker.sv =====
// Checker for the Ascii85 stream encoder: predicts characters and compares responses.
`timescale 1ns / 100ps

module ascii85_stream_encoder_checker (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_ready,
   input  a85s_pkg::a85s_req_type  req_data,
   input  wire                     rsp_valid,
   input  wire                     rsp_ready,
   input  a85s_pkg::a85s_rsp_type  rsp_data,
   output int                      fail_count,
   output int                      expected_left
);

   import a85s_pkg::*;

   // Predicted state of the open group: bytes right-aligned, and how many are held.
   logic [23:0]  group_bytes;
   logic [1:0]   group_count;
   a85s_rsp_type chars_due[$];
   int           errors = 0;

   // Queue the leading n_char base-85 characters of a word, most significant first.
   function automatic void queue_digits(logic [31:0] word, int n_char, bit stream_end);
      logic [6:0]   digit [A85S_DIGITS];
      logic [31:0]  rest;
      a85s_rsp_type ch;
      rest = word;
      for (int k = A85S_DIGITS - 1; k >= 0; k--) begin
         digit[k] = 7'(rest % A85S_BASE);
         rest = rest / A85S_BASE;
      end
      for (int k = 0; k < n_char; k++) begin
         ch.out_char = A85S_OFFSET + digit[k];
         ch.last_char = stream_end && (k == n_char - 1);
         chars_due.push_back(ch);
      end
   endfunction

   // Advance the predicted group by one request and queue the characters it releases.
   function automatic void encode_request_byte(a85s_req_type req);
      logic [31:0]  word;
      a85s_rsp_type ch;
      word = {group_bytes, req.data_byte};
      if (group_count == 2'd3) begin
         // A full group: an all-zero word collapses to a single 'z'.
         if (word == 32'd0) begin
            ch.out_char = A85S_ZERO_CHAR;
            ch.last_char = req.last_byte;
            chars_due.push_back(ch);
         end else begin
            queue_digits(word, A85S_DIGITS, req.last_byte);
         end
         group_bytes = '0;
         group_count = '0;
      end else if (!req.last_byte) begin
         group_bytes = word[23:0];
         group_count = group_count + 2'd1;
      end else begin
         // A short final group is zero padded and never uses the 'z' shortcut.
         word = word << (8 * (3 - group_count));
         queue_digits(word, int'(group_count) + 2, 1'b1);
         group_bytes = '0;
         group_count = '0;
      end
   endfunction

   // Compare each accepted response with the oldest character due, then predict.
   always @(posedge clock) begin : watch
      a85s_rsp_type due;
      if (reset) begin
         group_bytes = '0;
         group_count = '0;
         chars_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (chars_due.size() == 0) begin
               errors++;
               $display("%0t: response char %0d last %0b arrived with nothing due",
                        $time, rsp_data.out_char, rsp_data.last_char);
            end else begin
               due = chars_due.pop_front();
               if (rsp_data.out_char !== due.out_char) begin
                  errors++;
                  $display("%0t: out_char expected %0d, actual %0d",
                           $time, due.out_char, rsp_data.out_char);
               end
               if (rsp_data.last_char !== due.last_char) begin
                  errors++;
                  $display("%0t: last_char expected %0b, actual %0b",
                           $time, due.last_char, rsp_data.last_char);
               end
            end
         end
         if (req_valid && req_ready) begin
            encode_request_byte(req_data);
         end
      end
      fail_count <= errors;
      expected_left <= chars_due.size();
   end

endmodule

// ===== test/ascii85_stream_encoder_test.sv =====
// Top of the Ascii85 stream encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module ascii85_stream_encoder_test;

   import a85s_pkg::*;

   typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SPARSE} fill_kind_type;

   localparam int RANDOM_BYTES = 255;
   localparam int HOLD_AT_BYTE = 120;
   localparam int HOLD_CYCLES = 120;
   localparam int MID_DRAIN_AT = 220;
   localparam int TAIL_CYCLES = 30;
   localparam int DIRECTED_BYTES = 25;

   // Directed streams as {last, byte}: zero group, all-ones group, short groups of
   // zeros and ones, a zero group closing a stream, and a full group before a short one.
   localparam logic [8:0] DIRECTED [DIRECTED_BYTES] = '{
      9'h000, 9'h000, 9'h000, 9'h000,
      9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
      9'h100,
      9'h000, 9'h000, 9'h100,
      9'h1FF,
      9'h0FF, 9'h0FF, 9'h1FF,
      9'h000, 9'h000, 9'h000, 9'h100,
      9'h080, 9'h07F, 9'h001, 9'h0FE, 9'h155
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         rsp_ready = 1'b0;
   a85s_req_type req_data = '0;
   wire          req_ready;
   wire          rsp_valid;
   a85s_rsp_type rsp_data;
   int           fail_count;
   int           expected_left;

   // Coordination between the request side and the response side for the long hold.
   bit hold_request = 1'b0;
   bit hold_active = 1'b0;
   bit hold_done = 1'b0;
   int bytes_sent = 0;
   int burst_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   ascii85_stream_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ascii85_stream_encoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   // Lower the request valid for a gap of the given number of cycles.
   task automatic idle_gap(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Offer one request, wait for its acceptance, then pace the next one in bursts.
   task automatic send_byte(input logic [7:0] value, input logic stream_end);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= '{data_byte: value, last_byte: stream_end};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (bytes_sent == HOLD_AT_BYTE) begin
         hold_request = 1'b1;
      end
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
         if (hold_done || !hold_request) begin
            idle_gap($urandom_range(1, 6));
         end
      end else begin
         burst_left--;
      end
   endtask

   // Stop offering requests until every predicted character has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   // One well-formed stream of the given length; its final byte carries the last flag.
   task automatic send_stream(input int length, input fill_kind_type fill);
      logic [7:0] value;
      for (int i = 0; i < length; i++) begin
         case (fill)
            FILL_ZERO: value = 8'h00;
            FILL_ONES: value = 8'hFF;
            FILL_SPARSE: value = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
            default: value = 8'($urandom);
         endcase
         send_byte(value, i == length - 1);
      end
   endtask

   // Response side: runs of ready and stalls, plus one long hold that fills the block.
   initial begin : response_side
      int  run_left;
      int  hold_left;
      int  pick;
      bit  run_value;
      run_left = 0;
      hold_left = 0;
      run_value = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request && !hold_done && !hold_active) begin
            hold_active = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_active) begin
            rsp_ready <= 1'b0;
            hold_left--;
            if (hold_left == 0) begin
               hold_active = 1'b0;
               hold_done = 1'b1;
            end
         end else begin
            if (run_left == 0) begin
               pick = $urandom_range(0, 9);
               if (pick < 3) begin
                  run_value = 1'b1;
                  run_left = $urandom_range(20, 60);
               end else if (pick < 7) begin
                  run_value = 1'b1;
                  run_left = $urandom_range(1, 5);
               end else begin
                  run_value = 1'b0;
                  run_left = $urandom_range(1, 8);
               end
            end
            rsp_ready <= run_value;
            run_left--;
         end
         @(negedge clock);
      end
   end

   // Request side: reset, directed streams, random streams, then the verdict.
   initial begin : request_side
      int            random_sent;
      int            length;
      bit            mid_drained;
      fill_kind_type fill;
      random_sent = 0;
      mid_drained = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_BYTES; i++) begin
         send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      end
      drain_results();

      // Mostly random content, with zero groups and all-ones groups mixed in.
      while (random_sent < RANDOM_BYTES) begin
         length = ($urandom_range(0, 2) == 0) ? 4 * $urandom_range(1, 3)
                                              : $urandom_range(1, 12);
         case ($urandom_range(0, 9))
            0, 1: fill = FILL_ZERO;
            2: fill = FILL_ONES;
            3, 4: fill = FILL_SPARSE;
            default: fill = FILL_RANDOM;
         endcase
         send_stream(length, fill);
         random_sent += length;
         if (!mid_drained && bytes_sent >= MID_DRAIN_AT) begin
            drain_results();
            mid_drained = 1'b1;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule
